FILE: design/kwm_pkg.sv
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared types and constants for the k-way sorted stream merge.
// ----------------------------------------------------------------------------
`default_nettype none

package kwm_pkg;

    // Number of lists the block can hold heads for.
    localparam int MAX_LISTS = 16;
    // Field widths fixed by the item format.
    localparam int LIST_W    = 4;
    localparam int CNT_W     = 5;
    localparam int DATA_W    = 32;

    // Queue between front and back; depth must be a power of two.
    localparam int QDEPTH    = 2;
    localparam int Q_PTR_W   = $clog2(QDEPTH);
    localparam int Q_CNT_W   = $clog2(QDEPTH + 1);

    localparam logic [CNT_W-1:0] LIST_COUNT_RESET = CNT_W'(MAX_LISTS);

    // Item operation codes
    typedef enum logic {
        OP_ELEMENT = 1'b0,
        OP_END     = 1'b1
    } t_op;

    // One input item after acceptance
    typedef struct packed {
        t_op                       op;
        logic [LIST_W-1:0]         idx;
        logic signed [DATA_W-1:0]  value;
    } t_item;

    // One result item
    typedef struct packed {
        logic                      has_value;
        logic signed [DATA_W-1:0]  merged_value;
        logic [LIST_W-1:0]         source_list;
        logic                      request_valid;
        logic [LIST_W-1:0]         request_list;
        logic                      merge_done;
    } t_result;

endpackage

`default_nettype wire

FILE: design/kwm_front.sv
// ----------------------------------------------------------------------------
// kwm_front
// Input stage: registers each transfer and drops items for lists not in use.
// ----------------------------------------------------------------------------
`default_nettype none

module kwm_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [kwm_pkg::CNT_W-1:0]  i_eff_count,
    // input channel
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire kwm_pkg::t_item             i_item,
    // toward the queue
    output logic                            o_push,
    output kwm_pkg::t_item                  o_item,
    input  wire logic                       i_q_ready
);

    logic            r_valid;
    kwm_pkg::t_item  r_item;
    logic            w_in_range;
    logic            w_drain;

    // Lists at or above the active count take no part
    assign w_in_range = ({1'b0, r_item.idx} < i_eff_count);
    assign w_drain    = r_valid && (!w_in_range || i_q_ready);
    assign o_push     = r_valid && w_in_range && i_q_ready;
    assign o_item     = r_item;
    assign o_in_ready = !r_valid || w_drain;

    // Holding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_valid <= 1'b1;
                r_item  <= i_item;
            end else if (w_drain) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/kwm_queue.sv
// ----------------------------------------------------------------------------
// kwm_queue
// Short FIFO of items between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module kwm_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire kwm_pkg::t_item   i_item,
    output logic                  o_ready,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output kwm_pkg::t_item        o_item
);

    kwm_pkg::t_item                r_mem [kwm_pkg::QDEPTH];
    logic [kwm_pkg::Q_PTR_W-1:0]   r_wr_ptr;
    logic [kwm_pkg::Q_PTR_W-1:0]   r_rd_ptr;
    logic [kwm_pkg::Q_CNT_W-1:0]   r_count;

    assign o_ready = (r_count != kwm_pkg::Q_CNT_W'(kwm_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/kwm_back.sv
// ----------------------------------------------------------------------------
// kwm_back
// Merge engine: head store, readiness check, serial minimum scan, result reg.
// ----------------------------------------------------------------------------
`default_nettype none

module kwm_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [kwm_pkg::CNT_W-1:0]  i_eff_count,
    // from the queue
    input  wire logic                       i_q_valid,
    input  wire kwm_pkg::t_item             i_q_item,
    output logic                            o_q_pop,
    // result channel
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output kwm_pkg::t_result                o_result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_SCAN,
        S_EMIT
    } t_state;

    t_state                               r_state;
    logic [kwm_pkg::MAX_LISTS-1:0]        r_present;
    logic [kwm_pkg::MAX_LISTS-1:0]        r_finished;
    logic signed [kwm_pkg::DATA_W-1:0]    r_head_mem [kwm_pkg::MAX_LISTS];
    logic signed [kwm_pkg::DATA_W-1:0]    r_rd_data;

    logic [kwm_pkg::LIST_W-1:0]           r_scan_idx;
    logic                                 r_issue_on;
    logic                                 r_cmp_vld;
    logic [kwm_pkg::LIST_W-1:0]           r_cmp_idx;
    logic                                 r_have_min;
    logic signed [kwm_pkg::DATA_W-1:0]    r_min_val;
    logic [kwm_pkg::LIST_W-1:0]           r_min_idx;
    logic                                 r_wait;
    logic [kwm_pkg::LIST_W-1:0]           r_req_list;

    logic                                 r_out_valid;
    kwm_pkg::t_result                     r_result;

    logic                                 w_busy;
    logic                                 w_head_wr;
    logic [kwm_pkg::LIST_W-1:0]           w_last;
    logic                                 w_out_free;
    logic [kwm_pkg::MAX_LISTS-1:0]        w_missing;
    logic                                 w_any_missing;
    logic [kwm_pkg::LIST_W-1:0]           w_first_missing;

    assign o_q_pop     = (r_state == S_IDLE) && i_q_valid;
    assign w_busy      = r_present[i_q_item.idx] | r_finished[i_q_item.idx];
    assign w_head_wr   = o_q_pop && (i_q_item.op == kwm_pkg::OP_ELEMENT) && !w_busy;
    assign w_last      = kwm_pkg::LIST_W'(i_eff_count - kwm_pkg::CNT_W'(1));
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    // Lists in use that hold neither a head nor an end mark; lowest one wins
    always_comb begin
        for (int i = 0; i < kwm_pkg::MAX_LISTS; i++) begin
            w_missing[i] = !r_present[i] && !r_finished[i]
                           && (kwm_pkg::CNT_W'(i) < i_eff_count);
        end
        w_any_missing   = |w_missing;
        w_first_missing = '0;
        for (int i = kwm_pkg::MAX_LISTS - 1; i >= 0; i--) begin
            if (w_missing[i]) begin
                w_first_missing = kwm_pkg::LIST_W'(i);
            end
        end
    end

    // Head store: one write port, one registered read port for the scan
    always_ff @(posedge i_clk) begin
        if (w_head_wr) begin
            r_head_mem[i_q_item.idx] <= i_q_item.value;
        end
        r_rd_data <= r_head_mem[r_scan_idx];
    end

    // Control sequence and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_present   <= '0;
            r_finished  <= '0;
            r_issue_on  <= 1'b0;
            r_cmp_vld   <= 1'b0;
            r_have_min  <= 1'b0;
            r_wait      <= 1'b0;
            r_out_valid <= 1'b0;
            r_scan_idx  <= '0;
        end else begin
            // S_EMIT reloads the result register itself
            if (r_out_valid && i_out_ready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                // Apply one item to the head and end bits
                S_IDLE: begin
                    if (o_q_pop) begin
                        if (i_q_item.op == kwm_pkg::OP_END) begin
                            r_finished[i_q_item.idx] <= 1'b1;
                            r_state                  <= S_EVAL;
                        end else if (!w_busy) begin
                            r_present[i_q_item.idx]  <= 1'b1;
                            r_state                  <= S_EVAL;
                        end
                    end
                end
                // Either ask for a missing list or start the minimum scan
                S_EVAL: begin
                    if (w_any_missing) begin
                        r_wait     <= 1'b1;
                        r_req_list <= w_first_missing;
                        r_state    <= S_EMIT;
                    end else begin
                        r_wait     <= 1'b0;
                        r_scan_idx <= '0;
                        r_issue_on <= 1'b1;
                        r_cmp_vld  <= 1'b0;
                        r_have_min <= 1'b0;
                        r_state    <= S_SCAN;
                    end
                end
                // One head per cycle through a single comparator
                S_SCAN: begin
                    if (r_issue_on) begin
                        r_cmp_vld <= 1'b1;
                        r_cmp_idx <= r_scan_idx;
                        if (r_scan_idx == w_last) begin
                            r_issue_on <= 1'b0;
                        end else begin
                            r_scan_idx <= r_scan_idx + 1'b1;
                        end
                    end
                    if (r_cmp_vld) begin
                        // strict less keeps ties on the lower index
                        if (r_present[r_cmp_idx]
                            && (!r_have_min || r_rd_data < r_min_val)) begin
                            r_have_min <= 1'b1;
                            r_min_val  <= r_rd_data;
                            r_min_idx  <= r_cmp_idx;
                        end
                        if (r_cmp_idx == w_last) begin
                            r_cmp_vld <= 1'b0;
                            r_state   <= S_EMIT;
                        end
                    end
                end
                // Load the result register once it is free
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                        priority if (r_wait) begin
                            r_result.has_value     <= 1'b0;
                            r_result.merged_value  <= '0;
                            r_result.source_list   <= '0;
                            r_result.request_valid <= 1'b1;
                            r_result.request_list  <= r_req_list;
                            r_result.merge_done    <= 1'b0;
                        end else if (r_have_min) begin
                            r_present[r_min_idx]   <= 1'b0;
                            r_result.has_value     <= 1'b1;
                            r_result.merged_value  <= r_min_val;
                            r_result.source_list   <= r_min_idx;
                            r_result.request_valid <= 1'b1;
                            r_result.request_list  <= r_min_idx;
                            r_result.merge_done    <= 1'b0;
                        end else begin
                            r_present              <= '0;
                            r_finished             <= '0;
                            r_result.has_value     <= 1'b0;
                            r_result.merged_value  <= '0;
                            r_result.source_list   <= '0;
                            r_result.request_valid <= 1'b0;
                            r_result.request_list  <= '0;
                            r_result.merge_done    <= 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: design/k_way_sorted_stream_merge.sv
// ----------------------------------------------------------------------------
// k_way_sorted_stream_merge
// Merges up to sixteen ascending sorted lists into one ascending stream.
// ----------------------------------------------------------------------------
// Items enter through a registered front stage and a two-entry queue, so the
// input side keeps taking items while the merge engine works or a result
// waits. An item passes through the front register and the queue before it
// reaches the engine, and the engine handles one item at a time. An item for
// a list not in use is dropped by the front stage; an element over a held
// head or after an end mark is taken by the engine and discarded; neither
// gives a result. An item that leaves some list in use without a head or end
// mark loads a request result through the evaluate and emit states, once the
// result register is free. An item that completes the set of heads starts
// the minimum search, which reads the head store through its single
// registered read port, one list per cycle, into one shared signed
// comparator. The user must write list_count only while the block is idle;
// the block itself does not enforce this.
`default_nettype none

module k_way_sorted_stream_merge (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [kwm_pkg::CNT_W-1:0]         i_cfg_list_count,
    // input items
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic                              i_operation,
    input  wire logic [kwm_pkg::LIST_W-1:0]        i_list_index,
    input  wire logic signed [kwm_pkg::DATA_W-1:0] i_element_value,
    // result items
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic                                   o_has_value,
    output logic signed [kwm_pkg::DATA_W-1:0]      o_merged_value,
    output logic [kwm_pkg::LIST_W-1:0]             o_source_list,
    output logic                                   o_request_valid,
    output logic [kwm_pkg::LIST_W-1:0]             o_request_list,
    output logic                                   o_merge_done
);

    logic [kwm_pkg::CNT_W-1:0]  r_list_count;
    logic [kwm_pkg::CNT_W-1:0]  eff_count;
    kwm_pkg::t_item             in_item;
    kwm_pkg::t_item             front_item;
    kwm_pkg::t_item             q_item;
    logic                       front_push;
    logic                       q_ready;
    logic                       q_valid;
    logic                       q_pop;
    kwm_pkg::t_result           result;

    // Configuration register, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_list_count <= kwm_pkg::LIST_COUNT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_list_count <= i_cfg_list_count;
        end
    end

    // Zero acts as one, values past the maximum act as the maximum
    always_comb begin
        priority if (r_list_count == '0) begin
            eff_count = kwm_pkg::CNT_W'(1);
        end else if (r_list_count > kwm_pkg::CNT_W'(kwm_pkg::MAX_LISTS)) begin
            eff_count = kwm_pkg::CNT_W'(kwm_pkg::MAX_LISTS);
        end else begin
            eff_count = r_list_count;
        end
    end

    assign in_item.op    = kwm_pkg::t_op'(i_operation);
    assign in_item.idx   = i_list_index;
    assign in_item.value = i_element_value;

    kwm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_eff_count (eff_count),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_item      (in_item),
        .o_push      (front_push),
        .o_item      (front_item),
        .i_q_ready   (q_ready)
    );

    kwm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_item  (front_item),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    kwm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_eff_count (eff_count),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (result)
    );

    assign o_has_value     = result.has_value;
    assign o_merged_value  = result.merged_value;
    assign o_source_list   = result.source_list;
    assign o_request_valid = result.request_valid;
    assign o_request_list  = result.request_list;
    assign o_merge_done    = result.merge_done;

endmodule

`default_nettype wire

FILE: design/kwm_checker.sv
// ----------------------------------------------------------------------------
// kwm_checker
// Port-level checks on the merge block's result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module kwm_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              o_out_valid,
    input  wire logic                              i_out_ready,
    input  wire logic                              o_has_value,
    input  wire logic signed [kwm_pkg::DATA_W-1:0] o_merged_value,
    input  wire logic [kwm_pkg::LIST_W-1:0]        o_source_list,
    input  wire logic                              o_request_valid,
    input  wire logic [kwm_pkg::LIST_W-1:0]        o_request_list,
    input  wire logic                              o_merge_done
);

    // No result shows right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_merged_value) && $stable(o_request_list)))
        else $error("stalled result changed");

    // An emitted element always asks for its own list next
    a_emit_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_has_value) |->
            (o_request_valid && o_request_list == o_source_list && !o_merge_done))
        else $error("emission without matching request");

    // Completion carries nothing else
    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_merge_done) |->
            (!o_has_value && !o_request_valid && o_merged_value == 0))
        else $error("completion result not clean");

    // Exactly one of request and completion on every result
    a_req_xor_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_request_valid != o_merge_done))
        else $error("request and completion both or neither");

endmodule

bind k_way_sorted_stream_merge kwm_checker u_kwm_checker (.*);

`default_nettype wire
